// ===== design/avlu_pkg.sv =====
package avlu_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PERCENT_W  = 10;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_ENABLE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PERCENT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOWPASS_ENABLE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_FORM    = 2'd3;

    // output forms, the unused code falls back to plain
    localparam logic [1:0] FORM_PLAIN = 2'd0;
    localparam logic [1:0] FORM_SWAP  = 2'd1;
    localparam logic [1:0] FORM_MULAW = 2'd2;

    // |sample| * |percent| is at most 2^24
    localparam int MAG_W = 25;

    // floor(m / 100) == (m * RECIP) >> RECIP_SHIFT for every m below 2^30
    localparam int                RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] RECIP      = 26'd42949673;
    localparam int                RECIP_SHIFT = 32;
    localparam int                QUOT_W      = 18;

    // mu-law encoder
    localparam logic [14:0] MU_BIAS = 15'd132;
    localparam logic [14:0] MU_CLIP = 15'd32635;

    typedef struct packed {
        logic                        gain_enable;
        logic signed [PERCENT_W-1:0] gain_percent;
        logic                        lowpass_enable;
        logic [1:0]                  output_form;
    } cfg_t;

endpackage

// ===== design/avlu_gain.sv =====
module avlu_gain (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  avlu_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [avlu_pkg::SAMPLE_W-1:0] in_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [avlu_pkg::SAMPLE_W-1:0] out_sample
);
    import avlu_pkg::*;

    logic                       v1_reg;
    logic                       neg1_reg;
    logic [MAG_W-1:0]           mag1_reg;
    logic [SAMPLE_W-1:0]        sample1_reg;
    logic                       v2_reg;
    logic                       neg2_reg;
    logic [QUOT_W-1:0]          q2_reg;
    logic [SAMPLE_W-1:0]        sample2_reg;

    logic                       ready1;
    logic                       ready2;
    logic [SAMPLE_W-1:0]        sample_mag;
    logic [PERCENT_W-1:0]       pct_mag;
    logic [SAMPLE_W+PERCENT_W-1:0] prod_full;
    logic [MAG_W-1:0]           mag1_next;
    logic [MAG_W+RECIP_W-1:0]   recip_prod;
    logic [QUOT_W-1:0]          q2_next;
    logic [SAMPLE_W-1:0]        delta;
    logic [SAMPLE_W-1:0]        gained;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // stage 1: magnitude product, sign kept aside
    always_comb begin
        sample_mag = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
        pct_mag    = cfg.gain_percent[PERCENT_W-1] ? (~cfg.gain_percent + 1'b1)
                                                   : cfg.gain_percent;
        prod_full  = sample_mag * pct_mag;
        mag1_next  = prod_full[MAG_W-1:0];
    end

    // stage 2: divide by 100 through the reciprocal
    always_comb begin
        recip_prod = mag1_reg * RECIP;
        q2_next    = recip_prod[RECIP_SHIFT +: QUOT_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            neg1_reg    <= in_sample[SAMPLE_W-1] ^ cfg.gain_percent[PERCENT_W-1];
            mag1_reg    <= mag1_next;
            sample1_reg <= in_sample;
        end
        if (ready2 && v1_reg) begin
            neg2_reg    <= neg1_reg;
            q2_reg      <= q2_next;
            sample2_reg <= sample1_reg;
        end
    end

    // only the low 16 bits of the quotient survive the wrap
    always_comb begin
        delta  = neg2_reg ? (~q2_reg[SAMPLE_W-1:0] + 1'b1) : q2_reg[SAMPLE_W-1:0];
        gained = cfg.gain_enable ? (sample2_reg + delta) : sample2_reg;
    end

    assign out_valid  = v2_reg;
    assign out_sample = $signed(gained);

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !out_ready) |=> (v2_reg && $stable(q2_reg) && $stable(sample2_reg)))
        else $error("gain stage lost a stalled beat");

    a_stage1_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && ready2) |=> v2_reg)
        else $error("gain stage dropped a beat between stages");

endmodule

// ===== design/avlu_lowpass.sv =====
module avlu_lowpass (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  avlu_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [avlu_pkg::SAMPLE_W-1:0] in_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [avlu_pkg::SAMPLE_W-1:0] out_sample
);
    import avlu_pkg::*;

    logic                valid_reg;
    logic [SAMPLE_W-1:0] y_reg;
    logic [SAMPLE_W-1:0] prev_reg;

    logic [SAMPLE_W+2:0] x_ext;
    logic [SAMPLE_W+2:0] prev_ext;
    logic [SAMPLE_W+2:0] sum;
    logic [SAMPLE_W-1:0] y_next;
    logic                load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_ready && in_valid;

    // x + 7*prev fits 19 bits signed; dropping 3 bits is a floor shift
    always_comb begin
        x_ext    = {{3{in_sample[SAMPLE_W-1]}}, in_sample};
        prev_ext = {{3{prev_reg[SAMPLE_W-1]}}, prev_reg};
        sum      = x_ext + (prev_ext << 3) - prev_ext;
        y_next   = cfg.lowpass_enable ? sum[SAMPLE_W+2:3] : in_sample;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            prev_reg  <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load && cfg.lowpass_enable) begin
                prev_reg <= y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            y_reg <= y_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_sample = $signed(y_reg);

    a_prev_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && cfg.lowpass_enable) |=> (prev_reg == y_reg))
        else $error("filter state differs from the filtered beat");

    a_prev_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> $stable(prev_reg))
        else $error("filter state moved without a beat");

endmodule

// ===== design/avlu_format.sv =====
module avlu_format (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  avlu_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [avlu_pkg::SAMPLE_W-1:0] in_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [avlu_pkg::SAMPLE_W-1:0]       out_data
);
    import avlu_pkg::*;

    logic                valid_reg;
    logic [SAMPLE_W-1:0] data_reg;

    logic [SAMPLE_W-1:0] data_next;
    logic                sign;
    logic [SAMPLE_W-1:0] mag;
    logic [14:0]         mag_clip;
    logic [14:0]         biased;
    logic [2:0]          expo;
    logic [3:0]          mant;
    logic [7:0]          code;

    assign in_ready = !valid_reg || out_ready;

    // mu-law: clip, bias, exponent from the leading one, four mantissa bits
    always_comb begin
        sign     = in_sample[SAMPLE_W-1];
        mag      = sign ? (~in_sample + 1'b1) : in_sample;
        mag_clip = (mag > {1'b0, MU_CLIP}) ? MU_CLIP : mag[14:0];
        biased   = mag_clip + MU_BIAS;
        priority if (biased[14]) expo = 3'd7;
        else if (biased[13])     expo = 3'd6;
        else if (biased[12])     expo = 3'd5;
        else if (biased[11])     expo = 3'd4;
        else if (biased[10])     expo = 3'd3;
        else if (biased[9])      expo = 3'd2;
        else if (biased[8])      expo = 3'd1;
        else                     expo = 3'd0;
        mant = biased[({1'b0, expo} + 4'd3) +: 4];
        code = ~{sign, expo, mant};
    end

    always_comb begin
        unique case (cfg.output_form)
            FORM_SWAP:  data_next = {in_sample[7:0], in_sample[15:8]};
            FORM_MULAW: data_next = {8'h00, code};
            default:    data_next = in_sample;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("result register changed under a stall");

endmodule

// ===== design/audio_volume_lowpass_ulaw_path.sv =====
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_sample_in  signed 16-bit sample
// m_       out  m_valid/m_ready    m_data_out   16-bit pattern or mu-law byte
// cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// one beat per cycle sustained while m_ready stays high; m_valid rises once the beat has passed every stage below
// stages: magnitude product, reciprocal multiply, gain add and low-pass, output form
// the low-pass state updates in its own stage, so back-to-back beats chain correctly
// each stage takes a beat whenever it is empty or its successor moves
// aresetn clears all valid flags, the filter state and the configuration registers; data registers are not reset
module audio_volume_lowpass_ulaw_path (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [avlu_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  logic [avlu_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [avlu_pkg::SAMPLE_W-1:0]  s_sample_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [avlu_pkg::SAMPLE_W-1:0]         m_data_out
);
    import avlu_pkg::*;

    cfg_t cfg_reg;

    logic                       gain_valid;
    logic                       gain_ready;
    logic signed [SAMPLE_W-1:0] gain_sample;
    logic                       lp_valid;
    logic                       lp_ready;
    logic signed [SAMPLE_W-1:0] lp_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN_ENABLE:    cfg_reg.gain_enable    <= cfg_wdata[0];
                REG_GAIN_PERCENT:   cfg_reg.gain_percent   <= $signed(cfg_wdata[PERCENT_W-1:0]);
                REG_LOWPASS_ENABLE: cfg_reg.lowpass_enable <= cfg_wdata[0];
                REG_OUTPUT_FORM:    cfg_reg.output_form    <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    avlu_gain u_gain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_sample  (s_sample_in),
        .out_valid  (gain_valid),
        .out_ready  (gain_ready),
        .out_sample (gain_sample)
    );

    avlu_lowpass u_lowpass (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (gain_valid),
        .in_ready   (gain_ready),
        .in_sample  (gain_sample),
        .out_valid  (lp_valid),
        .out_ready  (lp_ready),
        .out_sample (lp_sample)
    );

    avlu_format u_format (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (lp_valid),
        .in_ready  (lp_ready),
        .in_sample (lp_sample),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data_out)
    );

endmodule
